[src/mdds_pkg.sv]
package mdds_pkg;

   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 256;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int EDGE_W    = $clog2(MAX_EDGES);

   // op codes of an input item
   localparam logic [2:0] OP_LOAD_NODE = 3'd0;
   localparam logic [2:0] OP_LOAD_PP   = 3'd1;
   localparam logic [2:0] OP_LOAD_PM   = 3'd2;
   localparam logic [2:0] OP_RUN       = 3'd3;
   localparam logic [2:0] OP_READ      = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_ODD = 2'd1;
   localparam logic [1:0] ST_NEG = 2'd2;
   localparam logic [1:0] ST_OVF = 2'd3;

   // register indexes
   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_REPS  = 2'd1;
   localparam logic [1:0] REG_NODES = 2'd2;

   // constraint kinds
   localparam logic KIND_PP = 1'b0;
   localparam logic KIND_PM = 1'b1;

   typedef struct packed {
      logic [2:0]        op;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] other_node;
      logic [30:0]       bound_value;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]  node_out;
      logic signed [31:0] delta;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic              kind;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] other;
      logic [30:0]       bound;
   } edge_type;

endpackage

[src/matching_dual_delta_solver.sv]
// channel  dir  handshake             payload
// req      in   req_valid/req_ready   mdds_pkg::req_type (op, node, other_node, bound_value)
// rsp      out  rsp_valid/rsp_ready   mdds_pkg::rsp_type (node_out, delta, status)
// csr      in   csr_valid/csr_ready   csr_index (0 mode, 1 repetitions, 2 node count), csr_data
//
// load items are written straight from the idle state and are accepted back to back
// a read item passes through S_WAIT, S_RD_OUT and S_OUT: the node delta memory has a registered read
// a run item keeps the block busy until its result: every step goes through one sequencer that
//   reads the edge store one entry at a time
// reset is synchronous and active high; it clears control state, deltas read as zero
// the result register holds an item until taken; loads still go in meanwhile
module matching_dual_delta_solver (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mdds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mdds_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_data
);

   localparam int NW = mdds_pkg::NODE_W;
   localparam int EW = mdds_pkg::EDGE_W;
   localparam logic [NW:0] NODE_LIM = (NW+1)'(mdds_pkg::MAX_NODES);
   localparam logic [NW:0] UNL = '1;
   localparam logic signed [35:0] SAT_HI = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] SAT_LO = 36'shF_8000_0000;

   typedef enum logic [5:0] {
      S_IDLE, S_WAIT, S_RD_OUT, S_OUT, S_RUN, S_CC,
      S_L_CLR, S_L_S, S_L_SCHK, S_L_POP, S_L_U, S_L_E, S_L_E1, S_L_E2, S_L_E3,
      S_D_CLR, S_C_LOOP, S_G_V, S_G_V1, S_G_K, S_G_K1, S_G_K2, S_G_W, S_G_W1,
      S_A_V, S_A_V1, S_CC_DONE,
      S_U_K, S_U_K1, S_U_K2, S_I_U, S_I_U1,
      S_R_CLR, S_R_IT, S_R_SCAN, S_R_SCAN1, S_R_K, S_R_K1, S_R_K2, S_R_RET,
      S_P_U, S_P_K, S_P_K1, S_P_K2, S_P_K3, S_Z_U, S_Z_U1, S_FIN
   } state_type;

   function automatic logic signed [35:0] ext32(input logic signed [31:0] x);
      return {{4{x[31]}}, x};
   endfunction

   function automatic logic signed [35:0] extb(input logic [30:0] b);
      return $signed({5'b0, b});
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = $signed(x[31:0]);
      end
      return r;
   endfunction

   state_type state_ff, ret_ff;

   // configuration
   logic        mode_ff;
   logic [3:0]  reps_ff;
   logic [NW:0] ncount_ff;

   // control
   logic [NW:0]   n_ff, idx_ff, cnt_ff, c_ff, head_ff, tail_ff, it_ff, x_ff;
   logic [EW:0]   k_ff, total_ff;
   logic [3:0]    cc_left_ff;
   logic [1:0]    err_ff, last_ff;
   logic          ovf_ff, phase_ff;
   logic [mdds_pkg::MAX_NODES-1:0] settled_ff;
   logic [NW-1:0] u_ff, nb_ff, rd_node_ff;
   logic          rsp_valid_ff;
   mdds_pkg::rsp_type rsp_data_ff, pend_ff;

   // working values
   mdds_pkg::edge_type e_ff;
   logic signed [35:0] best_ff, rem_ff;
   logic signed [31:0] nv_ff, xd_ff, inc_ff, nu_ff, nw_ff;

   // memories: write request and read address registers, registered read data
   logic signed [31:0] ub_mem [mdds_pkg::MAX_NODES];
   logic          ub_we_ff;
   logic [NW-1:0] ub_wa_ff, ub_ra_ff;
   logic signed [31:0] ub_wd_ff, ub_rd_ff;

   logic signed [31:0] nd_mem [mdds_pkg::MAX_NODES];
   logic [mdds_pkg::MAX_NODES-1:0] nd_vld_ff;
   logic          nd_we_ff;
   logic [NW-1:0] nd_wa_ff, nd_ra0_ff, nd_ra1_ff;
   logic signed [31:0] nd_wd_ff, nd_rd0_ff, nd_rd1_ff;

   logic signed [31:0] di_mem [mdds_pkg::MAX_NODES];
   logic          di_we_ff;
   logic [NW-1:0] di_wa_ff, di_ra_ff;
   logic signed [31:0] di_wd_ff, di_rd_ff;

   logic [NW:0]   lab_mem [mdds_pkg::MAX_NODES];
   logic          lab_we_ff;
   logic [NW-1:0] lab_wa_ff, lab_ra_ff;
   logic [NW:0]   lab_wd_ff, lab_rd_ff;

   logic [NW-1:0] q_mem [mdds_pkg::MAX_NODES];
   logic          q_we_ff;
   logic [NW-1:0] q_wa_ff, q_ra_ff, q_wd_ff, q_rd_ff;

   mdds_pkg::edge_type e_mem [mdds_pkg::MAX_EDGES];
   logic          e_we_ff;
   logic [EW-1:0] e_wa_ff, e_ra_ff;
   mdds_pkg::edge_type e_wd_ff, e_rd_ff;

   // datapath
   logic               rd_ok, gk_same, gk_use;
   logic signed [35:0] bfs_slack, gv_cand, pp_slack, pm_slack, pp_adj, gk_cand;
   logic signed [35:0] rk_cand, viol, vhalf;
   logic signed [31:0] av_sum, p_nu, p_base, p_nv;
   logic [1:0]         fin_status;
   logic [NW:0]        n_clamp;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rd_ok     = ({1'b0, e_rd_ff.node} < n_ff) && ({1'b0, e_rd_ff.other} < n_ff);
      bfs_slack = extb(e_ff.bound) - ext32(nd_rd0_ff) + ext32(nd_rd1_ff);
      gv_cand   = ext32(ub_rd_ff) - ext32(nd_rd0_ff);
      pp_slack  = extb(e_ff.bound) - ext32(nv_ff) - ext32(nd_rd1_ff);
      pm_slack  = extb(e_ff.bound) - ext32(nv_ff) + ext32(nd_rd1_ff);
      // halving rounds toward zero
      pp_adj    = pp_slack + $signed({35'b0, pp_slack[35]});
      gk_same   = (lab_rd_ff == c_ff);
      gk_use    = 1'b1;
      if (e_ff.kind == mdds_pkg::KIND_PP) begin
         gk_cand = gk_same ? (pp_adj >>> 1) : (pp_slack - ext32(di_rd_ff));
      end else begin
         gk_use  = !gk_same;
         gk_cand = pm_slack + ext32(di_rd_ff);
      end
      av_sum     = sat32(ext32(nd_rd0_ff) + ext32(di_rd_ff));
      rk_cand    = ext32(xd_ff) + extb(e_ff.bound);
      viol       = ext32(nd_rd0_ff) + ext32(nd_rd1_ff) - extb(e_ff.bound);
      vhalf      = viol >>> 1;
      p_nu       = sat32(ext32(nd_rd0_ff) - vhalf);
      // a self-referencing entry splits against the already lowered value
      p_base     = (e_ff.node == e_ff.other) ? nu_ff : nw_ff;
      p_nv       = sat32(ext32(p_base) - rem_ff);
      fin_status = ovf_ff ? mdds_pkg::ST_OVF : err_ff;
      if (ncount_ff == '0) begin
         n_clamp = (NW+1)'(1);
      end else if (ncount_ff > NODE_LIM) begin
         n_clamp = NODE_LIM;
      end else begin
         n_clamp = ncount_ff;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         reps_ff   <= 4'd1;
         ncount_ff <= (NW+1)'(1);
      end else if (csr_valid) begin
         case (csr_index)
            mdds_pkg::REG_MODE:  mode_ff   <= csr_data[0];
            mdds_pkg::REG_REPS:  reps_ff   <= csr_data[3:0];
            mdds_pkg::REG_NODES: ncount_ff <= csr_data[NW:0];
            default: ;
         endcase
      end
   end

   // memories, write first on a same-address collision
   always_ff @(posedge clock) begin
      if (ub_we_ff) ub_mem[ub_wa_ff] <= ub_wd_ff;
      ub_rd_ff <= (ub_we_ff && ub_wa_ff == ub_ra_ff) ? ub_wd_ff : ub_mem[ub_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_vld_ff <= '0;
      end else if (nd_we_ff) begin
         nd_vld_ff[nd_wa_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (nd_we_ff) nd_mem[nd_wa_ff] <= nd_wd_ff;
      if (nd_we_ff && nd_wa_ff == nd_ra0_ff) begin
         nd_rd0_ff <= nd_wd_ff;
      end else begin
         nd_rd0_ff <= nd_vld_ff[nd_ra0_ff] ? nd_mem[nd_ra0_ff] : '0;
      end
      if (nd_we_ff && nd_wa_ff == nd_ra1_ff) begin
         nd_rd1_ff <= nd_wd_ff;
      end else begin
         nd_rd1_ff <= nd_vld_ff[nd_ra1_ff] ? nd_mem[nd_ra1_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (di_we_ff) di_mem[di_wa_ff] <= di_wd_ff;
      di_rd_ff <= (di_we_ff && di_wa_ff == di_ra_ff) ? di_wd_ff : di_mem[di_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (lab_we_ff) lab_mem[lab_wa_ff] <= lab_wd_ff;
      lab_rd_ff <= (lab_we_ff && lab_wa_ff == lab_ra_ff) ? lab_wd_ff : lab_mem[lab_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (q_we_ff) q_mem[q_wa_ff] <= q_wd_ff;
      q_rd_ff <= (q_we_ff && q_wa_ff == q_ra_ff) ? q_wd_ff : q_mem[q_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (e_we_ff) e_mem[e_wa_ff] <= e_wd_ff;
      e_rd_ff <= (e_we_ff && e_wa_ff == e_ra_ff) ? e_wd_ff : e_mem[e_ra_ff];
   end

   // sequencer: a read is issued, S_WAIT covers the registered read, ret_ff resumes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= mdds_pkg::ST_OK;
         err_ff       <= mdds_pkg::ST_OK;
         n_ff         <= (NW+1)'(1);
         ub_we_ff     <= 1'b0;
         nd_we_ff     <= 1'b0;
         di_we_ff     <= 1'b0;
         lab_we_ff    <= 1'b0;
         q_we_ff      <= 1'b0;
         e_we_ff      <= 1'b0;
         settled_ff   <= '0;
      end else begin
         ub_we_ff  <= 1'b0;
         nd_we_ff  <= 1'b0;
         di_we_ff  <= 1'b0;
         lab_we_ff <= 1'b0;
         q_we_ff   <= 1'b0;
         e_we_ff   <= 1'b0;
         if (rsp_ready) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  case (req_data.op)
                     mdds_pkg::OP_LOAD_NODE: begin
                        ub_we_ff <= 1'b1;
                        ub_wa_ff <= req_data.node;
                        ub_wd_ff <= $signed({1'b0, req_data.bound_value});
                        nd_we_ff <= 1'b1;
                        nd_wa_ff <= req_data.node;
                        nd_wd_ff <= '0;
                        // node 0 opens a new problem
                        if (req_data.node == '0) begin
                           total_ff <= '0;
                           ovf_ff   <= 1'b0;
                        end
                     end
                     mdds_pkg::OP_LOAD_PP, mdds_pkg::OP_LOAD_PM: begin
                        if (total_ff[EW]) begin
                           ovf_ff  <= 1'b1;
                           last_ff <= mdds_pkg::ST_OVF;
                        end else begin
                           e_we_ff       <= 1'b1;
                           e_wa_ff       <= total_ff[EW-1:0];
                           e_wd_ff.kind  <= (req_data.op == mdds_pkg::OP_LOAD_PM);
                           e_wd_ff.node  <= req_data.node;
                           e_wd_ff.other <= req_data.other_node;
                           e_wd_ff.bound <= req_data.bound_value;
                           total_ff      <= total_ff + 1'b1;
                        end
                     end
                     mdds_pkg::OP_RUN: state_ff <= S_RUN;
                     mdds_pkg::OP_READ: begin
                        nd_ra0_ff  <= req_data.node;
                        rd_node_ff <= req_data.node;
                        ret_ff     <= S_RD_OUT;
                        state_ff   <= S_WAIT;
                     end
                     default: ;
                  endcase
               end
            end
            S_WAIT: state_ff <= ret_ff;
            S_RD_OUT: begin
               pend_ff.node_out <= rd_node_ff;
               pend_ff.delta    <= nd_rd0_ff;
               pend_ff.status   <= last_ff;
               state_ff         <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff  <= pend_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_RUN: begin
               n_ff   <= n_clamp;
               err_ff <= mdds_pkg::ST_OK;
               k_ff   <= '0;
               if (mode_ff) begin
                  state_ff <= S_U_K;
               end else if (reps_ff == '0) begin
                  state_ff <= S_FIN;
               end else begin
                  cc_left_ff <= reps_ff;
                  state_ff   <= S_CC;
               end
            end

            // component pass: label groups joined by tight plus-minus entries
            S_CC: begin
               idx_ff   <= '0;
               state_ff <= S_L_CLR;
            end
            S_L_CLR: begin
               if (idx_ff == n_ff) begin
                  idx_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_L_S;
               end else begin
                  lab_we_ff <= 1'b1;
                  lab_wa_ff <= idx_ff[NW-1:0];
                  lab_wd_ff <= UNL;
                  idx_ff    <= idx_ff + 1'b1;
               end
            end
            S_L_S: begin
               if (idx_ff == n_ff) begin
                  idx_ff   <= '0;
                  state_ff <= S_D_CLR;
               end else begin
                  lab_ra_ff <= idx_ff[NW-1:0];
                  ret_ff    <= S_L_SCHK;
                  state_ff  <= S_WAIT;
               end
            end
            S_L_SCHK: begin
               if (lab_rd_ff != UNL) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_L_S;
               end else begin
                  lab_we_ff <= 1'b1;
                  lab_wa_ff <= idx_ff[NW-1:0];
                  lab_wd_ff <= cnt_ff;
                  q_we_ff   <= 1'b1;
                  q_wa_ff   <= '0;
                  q_wd_ff   <= idx_ff[NW-1:0];
                  head_ff   <= '0;
                  tail_ff   <= (NW+1)'(1);
                  state_ff  <= S_L_POP;
               end
            end
            S_L_POP: begin
               if (head_ff == tail_ff) begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_L_S;
               end else begin
                  q_ra_ff  <= head_ff[NW-1:0];
                  ret_ff   <= S_L_U;
                  state_ff <= S_WAIT;
               end
            end
            S_L_U: begin
               u_ff     <= q_rd_ff;
               head_ff  <= head_ff + 1'b1;
               k_ff     <= '0;
               state_ff <= S_L_E;
            end
            S_L_E: begin
               if (k_ff == total_ff) begin
                  state_ff <= S_L_POP;
               end else begin
                  e_ra_ff  <= k_ff[EW-1:0];
                  ret_ff   <= S_L_E1;
                  state_ff <= S_WAIT;
               end
            end
            S_L_E1: begin
               e_ff <= e_rd_ff;
               if (e_rd_ff.kind == mdds_pkg::KIND_PM && rd_ok) begin
                  nd_ra0_ff <= e_rd_ff.node;
                  nd_ra1_ff <= e_rd_ff.other;
                  ret_ff    <= S_L_E2;
                  state_ff  <= S_WAIT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_L_E;
               end
            end
            S_L_E2: begin
               if (bfs_slack == '0 && (e_ff.node == u_ff || e_ff.other == u_ff)) begin
                  nb_ff     <= (e_ff.node == u_ff) ? e_ff.other : e_ff.node;
                  lab_ra_ff <= (e_ff.node == u_ff) ? e_ff.other : e_ff.node;
                  ret_ff    <= S_L_E3;
                  state_ff  <= S_WAIT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_L_E;
               end
            end
            S_L_E3: begin
               if (lab_rd_ff == UNL) begin
                  lab_we_ff <= 1'b1;
                  lab_wa_ff <= nb_ff;
                  lab_wd_ff <= cnt_ff;
                  q_we_ff   <= 1'b1;
                  q_wa_ff   <= tail_ff[NW-1:0];
                  q_wd_ff   <= nb_ff;
                  tail_ff   <= tail_ff + 1'b1;
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_L_E;
            end

            // per group smallest allowed increase
            S_D_CLR: begin
               if (idx_ff == n_ff) begin
                  c_ff     <= '0;
                  state_ff <= S_C_LOOP;
               end else begin
                  di_we_ff <= 1'b1;
                  di_wa_ff <= idx_ff[NW-1:0];
                  di_wd_ff <= '0;
                  idx_ff   <= idx_ff + 1'b1;
               end
            end
            S_C_LOOP: begin
               idx_ff <= '0;
               if (c_ff == cnt_ff) begin
                  state_ff <= S_A_V;
               end else begin
                  best_ff  <= SAT_HI;
                  state_ff <= S_G_V;
               end
            end
            S_G_V: begin
               if (idx_ff == n_ff) begin
                  inc_ff   <= sat32(best_ff);
                  idx_ff   <= '0;
                  state_ff <= S_G_W;
               end else begin
                  lab_ra_ff <= idx_ff[NW-1:0];
                  ub_ra_ff  <= idx_ff[NW-1:0];
                  nd_ra0_ff <= idx_ff[NW-1:0];
                  ret_ff    <= S_G_V1;
                  state_ff  <= S_WAIT;
               end
            end
            S_G_V1: begin
               if (lab_rd_ff != c_ff) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_G_V;
               end else begin
                  nv_ff <= nd_rd0_ff;
                  if (gv_cand < best_ff) best_ff <= gv_cand;
                  k_ff     <= '0;
                  state_ff <= S_G_K;
               end
            end
            S_G_K: begin
               if (k_ff == total_ff) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_G_V;
               end else begin
                  e_ra_ff  <= k_ff[EW-1:0];
                  ret_ff   <= S_G_K1;
                  state_ff <= S_WAIT;
               end
            end
            S_G_K1: begin
               e_ff <= e_rd_ff;
               if (e_rd_ff.node == idx_ff[NW-1:0] && rd_ok) begin
                  nd_ra1_ff <= e_rd_ff.other;
                  lab_ra_ff <= e_rd_ff.other;
                  di_ra_ff  <= e_rd_ff.other;
                  ret_ff    <= S_G_K2;
                  state_ff  <= S_WAIT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_G_K;
               end
            end
            S_G_K2: begin
               if (e_ff.kind == mdds_pkg::KIND_PP && gk_same && pp_slack[0] &&
                   err_ff == mdds_pkg::ST_OK) begin
                  err_ff <= mdds_pkg::ST_ODD;
               end
               if (gk_use && gk_cand < best_ff) best_ff <= gk_cand;
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_G_K;
            end
            S_G_W: begin
               if (idx_ff == n_ff) begin
                  c_ff     <= c_ff + 1'b1;
                  state_ff <= S_C_LOOP;
               end else begin
                  lab_ra_ff <= idx_ff[NW-1:0];
                  ret_ff    <= S_G_W1;
                  state_ff  <= S_WAIT;
               end
            end
            S_G_W1: begin
               if (lab_rd_ff == c_ff) begin
                  di_we_ff <= 1'b1;
                  di_wa_ff <= idx_ff[NW-1:0];
                  di_wd_ff <= inc_ff;
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_G_W;
            end

            // apply increases
            S_A_V: begin
               if (idx_ff == n_ff) begin
                  state_ff <= S_CC_DONE;
               end else begin
                  di_ra_ff  <= idx_ff[NW-1:0];
                  nd_ra0_ff <= idx_ff[NW-1:0];
                  ret_ff    <= S_A_V1;
                  state_ff  <= S_WAIT;
               end
            end
            S_A_V1: begin
               if ((di_rd_ff < 0 || av_sum < 0) && err_ff == mdds_pkg::ST_OK) begin
                  err_ff <= mdds_pkg::ST_NEG;
               end
               nd_we_ff <= 1'b1;
               nd_wa_ff <= idx_ff[NW-1:0];
               nd_wd_ff <= av_sum;
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_A_V;
            end
            S_CC_DONE: begin
               if (cc_left_ff > 4'd1) begin
                  cc_left_ff <= cc_left_ff - 1'b1;
                  state_ff   <= S_CC;
               end else begin
                  state_ff <= S_FIN;
               end
            end

            // shortest path: lower bounds to the smallest plus-plus bound
            S_U_K: begin
               if (k_ff == total_ff) begin
                  idx_ff   <= '0;
                  state_ff <= S_I_U;
               end else begin
                  e_ra_ff  <= k_ff[EW-1:0];
                  ret_ff   <= S_U_K1;
                  state_ff <= S_WAIT;
               end
            end
            S_U_K1: begin
               e_ff <= e_rd_ff;
               if (e_rd_ff.kind == mdds_pkg::KIND_PP && rd_ok) begin
                  ub_ra_ff <= e_rd_ff.node;
                  ret_ff   <= S_U_K2;
                  state_ff <= S_WAIT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_U_K;
               end
            end
            S_U_K2: begin
               if (extb(e_ff.bound) < ext32(ub_rd_ff)) begin
                  ub_we_ff <= 1'b1;
                  ub_wa_ff <= e_ff.node;
                  ub_wd_ff <= $signed({1'b0, e_ff.bound});
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_U_K;
            end
            S_I_U: begin
               if (idx_ff == n_ff) begin
                  phase_ff <= 1'b0;
                  state_ff <= S_R_CLR;
               end else begin
                  ub_ra_ff <= idx_ff[NW-1:0];
                  ret_ff   <= S_I_U1;
                  state_ff <= S_WAIT;
               end
            end
            S_I_U1: begin
               nd_we_ff <= 1'b1;
               nd_wa_ff <= idx_ff[NW-1:0];
               nd_wd_ff <= ub_rd_ff;
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_I_U;
            end

            // relaxation: minimum scan over unsettled nodes, then its in-entries
            S_R_CLR: begin
               settled_ff <= '0;
               it_ff      <= '0;
               state_ff   <= S_R_IT;
            end
            S_R_IT: begin
               if (it_ff == n_ff) begin
                  state_ff <= S_R_RET;
               end else begin
                  idx_ff   <= '0;
                  x_ff     <= n_ff;
                  state_ff <= S_R_SCAN;
               end
            end
            S_R_SCAN: begin
               if (idx_ff == n_ff) begin
                  if (x_ff == n_ff) begin
                     state_ff <= S_R_RET;
                  end else begin
                     settled_ff[x_ff[NW-1:0]] <= 1'b1;
                     k_ff     <= '0;
                     state_ff <= S_R_K;
                  end
               end else if (settled_ff[idx_ff[NW-1:0]]) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  nd_ra0_ff <= idx_ff[NW-1:0];
                  ret_ff    <= S_R_SCAN1;
                  state_ff  <= S_WAIT;
               end
            end
            S_R_SCAN1: begin
               if (x_ff == n_ff || nd_rd0_ff < xd_ff) begin
                  x_ff  <= idx_ff;
                  xd_ff <= nd_rd0_ff;
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_R_SCAN;
            end
            S_R_K: begin
               if (k_ff == total_ff) begin
                  it_ff    <= it_ff + 1'b1;
                  state_ff <= S_R_IT;
               end else begin
                  e_ra_ff  <= k_ff[EW-1:0];
                  ret_ff   <= S_R_K1;
                  state_ff <= S_WAIT;
               end
            end
            S_R_K1: begin
               e_ff <= e_rd_ff;
               if (e_rd_ff.kind == mdds_pkg::KIND_PM && rd_ok &&
                   {1'b0, e_rd_ff.other} == x_ff) begin
                  nd_ra0_ff <= e_rd_ff.node;
                  ret_ff    <= S_R_K2;
                  state_ff  <= S_WAIT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_R_K;
               end
            end
            S_R_K2: begin
               if (ext32(nd_rd0_ff) > rk_cand) begin
                  nd_we_ff <= 1'b1;
                  nd_wa_ff <= e_ff.node;
                  nd_wd_ff <= sat32(rk_cand);
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_R_K;
            end
            S_R_RET: begin
               idx_ff   <= '0;
               state_ff <= phase_ff ? S_Z_U : S_P_U;
            end

            // split plus-plus violations by owning node, then load order
            S_P_U: begin
               if (idx_ff == n_ff) begin
                  phase_ff <= 1'b1;
                  state_ff <= S_R_CLR;
               end else begin
                  k_ff     <= '0;
                  state_ff <= S_P_K;
               end
            end
            S_P_K: begin
               if (k_ff == total_ff) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_P_U;
               end else begin
                  e_ra_ff  <= k_ff[EW-1:0];
                  ret_ff   <= S_P_K1;
                  state_ff <= S_WAIT;
               end
            end
            S_P_K1: begin
               e_ff <= e_rd_ff;
               if (e_rd_ff.kind == mdds_pkg::KIND_PP && rd_ok &&
                   e_rd_ff.node == idx_ff[NW-1:0]) begin
                  nd_ra0_ff <= e_rd_ff.node;
                  nd_ra1_ff <= e_rd_ff.other;
                  ret_ff    <= S_P_K2;
                  state_ff  <= S_WAIT;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_P_K;
               end
            end
            S_P_K2: begin
               if (viol > 0) begin
                  rem_ff   <= viol - vhalf;
                  nu_ff    <= p_nu;
                  nw_ff    <= nd_rd1_ff;
                  nd_we_ff <= 1'b1;
                  nd_wa_ff <= e_ff.node;
                  nd_wd_ff <= p_nu;
                  state_ff <= S_P_K3;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_P_K;
               end
            end
            S_P_K3: begin
               nd_we_ff <= 1'b1;
               nd_wa_ff <= e_ff.other;
               nd_wd_ff <= p_nv;
               if ((nu_ff < 0 || p_nv < 0) && err_ff == mdds_pkg::ST_OK) begin
                  err_ff <= mdds_pkg::ST_NEG;
               end
               k_ff     <= k_ff + 1'b1;
               state_ff <= S_P_K;
            end

            // all deltas zero falls back to one component pass
            S_Z_U: begin
               if (idx_ff == n_ff) begin
                  cc_left_ff <= 4'd1;
                  state_ff   <= S_CC;
               end else begin
                  nd_ra0_ff <= idx_ff[NW-1:0];
                  ret_ff    <= S_Z_U1;
                  state_ff  <= S_WAIT;
               end
            end
            S_Z_U1: begin
               if (nd_rd0_ff != '0) begin
                  state_ff <= S_FIN;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_Z_U;
               end
            end
            S_FIN: begin
               last_ff          <= fin_status;
               pend_ff.node_out <= '0;
               pend_ff.delta    <= '0;
               pend_ff.status   <= fin_status;
               state_ff         <= S_OUT;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[src/mdds_checker.sv]
module mdds_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mdds_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mdds_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // a run keeps the block busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == mdds_pkg::OP_RUN |=> !req_ready)
      else $error("item taken right after a run");

   // a read waits on the delta memory
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == mdds_pkg::OP_READ |=> !req_ready)
      else $error("item taken right after a read");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind matching_dual_delta_solver mdds_checker u_mdds_checker (.*);

[verif/matching_dual_delta_solver_tb.sv]
`timescale 1ns / 1ps

module matching_dual_delta_solver_tb;
   import mdds_pkg::*;

   localparam int  NUM_ITEMS   = 500;
   localparam int  CYCLE_LIMIT = 5000000;
   localparam int  UNLABELLED  = -1;
   localparam logic [2:0] OP_NOP = 3'd5;   // first unused op code
   localparam longint I32_MAX = 64'sd2147483647;
   localparam longint I32_MIN = -64'sd2147483648;

   // a directed row is either a register write or an item, with an optional typed answer
   typedef struct {
      bit         is_csr;
      logic [1:0] csr_idx;
      logic [6:0] csr_val;
      req_type    item;
      bit         chk;
      rsp_type    answer;
   } stim_row;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0] csr_index = '0;
   logic [6:0] csr_data = '0;

   matching_dual_delta_solver u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // mirror of the solver state
   int   bound_mem [MAX_NODES];
   int   delta_mem [MAX_NODES];
   int   incr_mem  [MAX_NODES];
   int   group_of  [MAX_NODES];
   bit   settled   [MAX_NODES];
   bit   ever_loaded [MAX_NODES];
   int   bfs_fifo  [MAX_NODES];
   logic entry_kind  [MAX_EDGES];
   int   entry_owner [MAX_EDGES];
   int   entry_peer  [MAX_EDGES];
   int   entry_bound [MAX_EDGES];
   int   entry_count;
   bit   store_overflow;
   logic [1:0] saved_status;
   logic [1:0] run_status;
   int   live_nodes;
   logic mode_reg;
   logic [3:0] reps_reg;
   logic [6:0] nodes_reg;

   rsp_type delta_results [$];   // results still owed by the block
   int      errors;
   int      cycles;
   int      sent;
   bit      calm;                // no idling on either side while set
   bit      dir_chk;
   rsp_type dir_answer;
   int      ready_left;

   function automatic int sat32(longint x);
      if (x > I32_MAX) return int'(I32_MAX);
      if (x < I32_MIN) return int'(I32_MIN);
      return int'(x);
   endfunction

   function automatic void flag_error(logic [1:0] code);
      if (run_status == ST_OK) run_status = code;
   endfunction

   function automatic bit entry_live(int k);
      return entry_owner[k] < live_nodes && entry_peer[k] < live_nodes;
   endfunction

   // flood fill over tight plus-minus entries, returns number of groups
   function automatic int label_groups();
      int count, head, tail, u, a, b, x;
      longint slack;
      count = 0;
      for (int s = 0; s < live_nodes; s++) group_of[s] = UNLABELLED;
      for (int s = 0; s < live_nodes; s++) begin
         if (group_of[s] != UNLABELLED) continue;
         group_of[s] = count;
         head = 0;
         tail = 0;
         bfs_fifo[tail++] = s;
         while (head < tail) begin
            u = bfs_fifo[head++];
            for (int k = 0; k < entry_count; k++) begin
               if (entry_kind[k] != KIND_PM || !entry_live(k)) continue;
               a = entry_owner[k];
               b = entry_peer[k];
               slack = longint'(entry_bound[k]) - delta_mem[a] + delta_mem[b];
               if (slack != 0) continue;
               if (a == u) x = b;
               else if (b == u) x = a;
               else continue;
               if (group_of[x] == UNLABELLED && tail < MAX_NODES) begin
                  group_of[x] = count;
                  bfs_fifo[tail++] = x;
               end
            end
         end
         count++;
      end
      return count;
   endfunction

   // largest common increase the bounds allow for group c
   function automatic longint group_headroom(int c);
      longint best, slack, cand;
      int w;
      best = I32_MAX;
      for (int v = 0; v < live_nodes; v++) begin
         if (group_of[v] != c) continue;
         if (longint'(bound_mem[v]) - delta_mem[v] < best)
            best = longint'(bound_mem[v]) - delta_mem[v];
         for (int k = 0; k < entry_count; k++) begin
            if (entry_owner[k] != v || !entry_live(k)) continue;
            w = entry_peer[k];
            if (entry_kind[k] == KIND_PP) begin
               slack = longint'(entry_bound[k]) - delta_mem[v] - delta_mem[w];
               if (group_of[w] == c) begin
                  // odd slack inside a group cannot be split evenly
                  if (slack % 2 != 0) flag_error(ST_ODD);
                  cand = slack / 2;
               end else begin
                  cand = slack - incr_mem[w];
               end
            end else begin
               if (group_of[w] == c) continue;
               slack = longint'(entry_bound[k]) - delta_mem[v] + delta_mem[w];
               cand = slack + incr_mem[w];
            end
            if (cand < best) best = cand;
         end
      end
      return best;
   endfunction

   function automatic void group_pass();
      int count, inc;
      count = label_groups();
      for (int v = 0; v < live_nodes; v++) incr_mem[v] = 0;
      for (int c = 0; c < count; c++) begin
         inc = sat32(group_headroom(c));
         for (int v = 0; v < live_nodes; v++)
            if (group_of[v] == c) incr_mem[v] = inc;
      end
      for (int v = 0; v < live_nodes; v++) begin
         if (incr_mem[v] < 0) flag_error(ST_NEG);
         delta_mem[v] = sat32(longint'(delta_mem[v]) + incr_mem[v]);
         if (delta_mem[v] < 0) flag_error(ST_NEG);
      end
   endfunction

   // dijkstra by minimum scan over plus-minus entries
   function automatic void relax_deltas();
      int x, u;
      longint cand;
      for (int i = 0; i < live_nodes; i++) settled[i] = 1'b0;
      for (int it = 0; it < live_nodes; it++) begin
         x = live_nodes;
         for (int i = 0; i < live_nodes; i++)
            if (!settled[i] && (x == live_nodes || delta_mem[i] < delta_mem[x])) x = i;
         if (x == live_nodes) break;
         settled[x] = 1'b1;
         for (int k = 0; k < entry_count; k++) begin
            if (entry_kind[k] != KIND_PM || !entry_live(k) || entry_peer[k] != x) continue;
            u = entry_owner[k];
            cand = longint'(delta_mem[x]) + entry_bound[k];
            if (longint'(delta_mem[u]) > cand) delta_mem[u] = sat32(cand);
         end
      end
   endfunction

   function automatic void path_update();
      bit all_zero;
      int v;
      longint viol, half;
      all_zero = 1'b1;
      for (int k = 0; k < entry_count; k++)
         if (entry_kind[k] == KIND_PP && entry_live(k) &&
             entry_bound[k] < bound_mem[entry_owner[k]])
            bound_mem[entry_owner[k]] = entry_bound[k];
      for (int u = 0; u < live_nodes; u++) delta_mem[u] = bound_mem[u];
      relax_deltas();
      // split plus-plus violations, owner by owner then in load order
      for (int u = 0; u < live_nodes; u++) begin
         for (int k = 0; k < entry_count; k++) begin
            if (entry_kind[k] != KIND_PP || !entry_live(k) || entry_owner[k] != u) continue;
            v = entry_peer[k];
            viol = longint'(delta_mem[u]) + delta_mem[v] - entry_bound[k];
            if (viol <= 0) continue;
            half = viol / 2;
            delta_mem[u] = sat32(longint'(delta_mem[u]) - half);
            delta_mem[v] = sat32(longint'(delta_mem[v]) - (viol - half));
            if (delta_mem[u] < 0 || delta_mem[v] < 0) flag_error(ST_NEG);
         end
      end
      relax_deltas();
      for (int u = 0; u < live_nodes; u++)
         if (delta_mem[u] != 0) all_zero = 1'b0;
      if (all_zero) group_pass();
   endfunction

   // applies one accepted item, returns 1 when it yields a result
   function automatic bit solve_item(req_type q, output rsp_type r);
      int nd;
      nd = int'(q.node);
      r = '0;
      case (q.op)
         OP_LOAD_NODE: begin
            // loading node 0 starts a new problem
            if (nd == 0) begin
               entry_count = 0;
               store_overflow = 1'b0;
            end
            bound_mem[nd] = int'(q.bound_value);
            delta_mem[nd] = 0;
            ever_loaded[nd] = 1'b1;
            return 1'b0;
         end
         OP_LOAD_PP, OP_LOAD_PM: begin
            if (entry_count >= MAX_EDGES) begin
               store_overflow = 1'b1;
               saved_status = ST_OVF;
               return 1'b0;
            end
            entry_kind[entry_count]  = (q.op == OP_LOAD_PP) ? KIND_PP : KIND_PM;
            entry_owner[entry_count] = nd;
            entry_peer[entry_count]  = int'(q.other_node);
            entry_bound[entry_count] = int'(q.bound_value);
            entry_count++;
            return 1'b0;
         end
         OP_RUN: begin
            live_nodes = (nodes_reg < 1) ? 1 : (nodes_reg > MAX_NODES) ? MAX_NODES : nodes_reg;
            run_status = ST_OK;
            if (mode_reg == 1'b0) begin
               for (int i = 0; i < reps_reg; i++) group_pass();
            end else begin
               path_update();
            end
            saved_status = store_overflow ? ST_OVF : run_status;
            r.status = saved_status;
            return 1'b1;
         end
         OP_READ: begin
            r.node_out = q.node;
            r.delta = delta_mem[nd];
            r.status = saved_status;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic report(input string what, input longint want, input longint got);
      $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
      errors++;
   endtask

   // prediction and checking both happen at the rising edge
   always @(posedge clock) begin
      rsp_type pred, want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE:  mode_reg = csr_data[0];
               REG_REPS:  reps_reg = csr_data[3:0];
               REG_NODES: nodes_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (solve_item(req_data, pred))
               delta_results.push_back(dir_chk ? dir_answer : pred);
         end
         if (rsp_valid && rsp_ready) begin
            if (delta_results.size() == 0) begin
               report("unexpected item, node", -1, rsp_data.node_out);
            end else begin
               want = delta_results.pop_front();
               if (rsp_data.node_out !== want.node_out)
                  report("node_out", want.node_out, rsp_data.node_out);
               if (rsp_data.delta !== want.delta)
                  report("delta", want.delta, rsp_data.delta);
               if (rsp_data.status !== want.status)
                  report("status", want.status, rsp_data.status);
            end
         end
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items owed", cycles, delta_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side stalls: bursts of ready, mostly short stalls, a few long ones
   always @(negedge clock) begin
      if (ready_left == 0) begin
         if (calm || $urandom_range(0, 99) < 60) begin
            rsp_ready = 1'b1;
            ready_left = $urandom_range(1, 20);
         end else begin
            rsp_ready = 1'b0;
            ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(1, 3);
         end
      end
      ready_left--;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(input req_type q, input bit chk, input rsp_type answer);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = q;
      dir_chk = chk;
      dir_answer = answer;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (q.op <= OP_READ) sent++;
   endtask

   task automatic send_op(input logic [2:0] op, input int nd, input int ot, input int bv);
      req_type q;
      q.op = op;
      q.node = nd[NODE_W-1:0];
      q.other_node = ot[NODE_W-1:0];
      q.bound_value = bv[30:0];
      send_item(q, 1'b0, '0);
   endtask

   // registers change only once all owed items are back and the block settled
   task automatic wait_idle();
      req_valid = 1'b0;
      while (delta_results.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [6:0] val);
      csr_index = idx;
      csr_data = val;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic int rand_bound();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(0, 12);
      if (r < 70) return $urandom_range(0, 64);
      if (r < 85) return $urandom() & 32'h7fff_ffff;
      if (r < 95) return 32'h7fff_ffff;
      return 0;
   endfunction

   function automatic int live_count(logic [6:0] raw);
      return (raw < 1) ? 1 : (raw > MAX_NODES) ? MAX_NODES : int'(raw);
   endfunction

   // one random problem: maybe new registers, node loads, entries, runs and reads
   task automatic random_problem(input bit fresh_csr, input bit overflow_case);
      logic [6:0] raw_nodes;
      logic [3:0] reps;
      int n, entries, rounds, r;
      if (fresh_csr || overflow_case) begin
         wait_idle();
         r = $urandom_range(0, 9);
         raw_nodes = (r < 7) ? 7'($urandom_range(1, 6)) :
                     (r == 7) ? 7'd64 : (r == 8) ? 7'd127 : 7'($urandom_range(0, 100));
         r = $urandom_range(0, 9);
         reps = (r < 5) ? 4'($urandom_range(1, 3)) : (r < 7) ? 4'd15 :
                (r == 7) ? 4'd0 : 4'($urandom_range(0, 15));
         if (live_count(raw_nodes) > 8 && reps > 2) reps = 4'd2;
         if (overflow_case) begin
            raw_nodes = 7'd2;
            reps = 4'd1;
         end
         write_csr(REG_MODE, 7'($urandom_range(0, 1)));
         write_csr(REG_REPS, {3'($urandom()), reps});
         write_csr(REG_NODES, raw_nodes);
      end
      calm = ($urandom_range(0, 4) == 0);
      n = live_count(nodes_reg);
      send_op(OP_LOAD_NODE, 0, $urandom_range(0, 63), rand_bound());
      for (int v = 1; v < n; v++) send_op(OP_LOAD_NODE, v, $urandom_range(0, 63), rand_bound());
      if ($urandom_range(0, 3) == 0)
         send_op(OP_LOAD_NODE, $urandom_range(1, 63), $urandom_range(0, 63), rand_bound());
      entries = overflow_case ? MAX_EDGES + $urandom_range(1, 3) : $urandom_range(0, 8);
      for (int k = 0; k < entries; k++) begin
         if ($urandom_range(0, 9) == 0)
            send_op($urandom_range(0, 1) ? OP_LOAD_PP : OP_LOAD_PM,
                    $urandom_range(0, 63), $urandom_range(0, 63), rand_bound());
         else
            send_op($urandom_range(0, 1) ? OP_LOAD_PP : OP_LOAD_PM,
                    $urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_bound());
      end
      rounds = $urandom_range(1, 3);
      for (int j = 0; j < rounds; j++) begin
         send_op(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 4) == 0)
               send_op(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
            else
               send_op(OP_READ, $urandom_range(0, n - 1), $urandom_range(0, 63), $urandom());
         end
         // sometimes tweak a bound between runs, or send an unused op
         if ($urandom_range(0, 3) == 0)
            send_op(OP_LOAD_NODE, $urandom_range(1, 63), $urandom_range(0, 63), rand_bound());
         if ($urandom_range(0, 7) == 0)
            send_op(3'($urandom_range(5, 7)), $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom());
      end
   endtask

   function automatic stim_row row_cfg(logic [1:0] idx, logic [6:0] val);
      stim_row s;
      s = '{default: '0};
      s.is_csr = 1'b1;
      s.csr_idx = idx;
      s.csr_val = val;
      return s;
   endfunction

   function automatic stim_row row_item(logic [2:0] op, int nd, int ot, int bv);
      stim_row s;
      s = '{default: '0};
      s.item.op = op;
      s.item.node = nd[NODE_W-1:0];
      s.item.other_node = ot[NODE_W-1:0];
      s.item.bound_value = bv[30:0];
      return s;
   endfunction

   function automatic stim_row row_chk(logic [2:0] op, int nd, int dl, logic [1:0] st);
      stim_row s;
      s = row_item(op, nd, 0, 0);
      s.chk = 1'b1;
      s.answer.node_out = (op == OP_RUN) ? '0 : nd[NODE_W-1:0];
      s.answer.delta = dl;
      s.answer.status = st;
      return s;
   endfunction

   stim_row directed [];

   initial begin
      bit overflow_done;
      errors = 0;
      cycles = 0;
      sent = 0;
      calm = 1'b0;
      dir_chk = 1'b0;
      dir_answer = '0;
      ready_left = 0;
      entry_count = 0;
      store_overflow = 1'b0;
      saved_status = ST_OK;
      run_status = ST_OK;
      live_nodes = 1;
      mode_reg = 1'b0;
      reps_reg = 4'd1;
      nodes_reg = 7'd1;
      overflow_done = 1'b0;
      for (int i = 0; i < MAX_NODES; i++) begin
         bound_mem[i] = 0;
         delta_mem[i] = 0;
         incr_mem[i] = 0;
         group_of[i] = UNLABELLED;
         ever_loaded[i] = 1'b0;
      end

      directed = '{
         // deltas read as zero after reset, extremes of the node field
         row_chk(OP_READ, 0, 0, ST_OK),
         row_chk(OP_READ, 63, 0, ST_OK),
         // unused ops give nothing back
         row_item(OP_NOP, 63, 63, 32'h7fff_ffff),
         row_item(3'd7, 0, 0, 0),
         // one node, one pass: delta climbs to its bound
         row_item(OP_LOAD_NODE, 0, 0, 10),
         row_chk(OP_RUN, 0, 0, ST_OK),
         row_chk(OP_READ, 0, 10, ST_OK),
         // self plus-plus entry with odd slack 3 gives half of it and flags odd
         row_item(OP_LOAD_NODE, 0, 0, 100),
         row_item(OP_LOAD_PP, 0, 0, 3),
         row_chk(OP_RUN, 0, 0, ST_ODD),
         row_chk(OP_READ, 0, 1, ST_ODD),
         // two nodes tied by plus-minus entries, maximum bound
         row_cfg(REG_NODES, 7'd2),
         row_item(OP_LOAD_NODE, 0, 0, 32'h7fff_ffff),
         row_item(OP_LOAD_NODE, 1, 0, 7),
         row_item(OP_LOAD_PM, 0, 1, 0),
         row_item(OP_LOAD_PM, 1, 0, 2),
         row_item(OP_RUN, 0, 0, 0),
         row_item(OP_READ, 1, 0, 0),
         // shortest-path mode with a plus-plus split
         row_cfg(REG_MODE, 7'd1),
         row_item(OP_LOAD_PP, 0, 1, 5),
         row_item(OP_RUN, 0, 0, 0),
         row_item(OP_READ, 0, 0, 0),
         // component mode with no passes keeps everything, then the most passes
         row_cfg(REG_REPS, 7'd0),
         row_cfg(REG_MODE, 7'd0),
         row_chk(OP_RUN, 0, 0, ST_OK),
         row_cfg(REG_REPS, 7'd15),
         row_item(OP_RUN, 0, 0, 0),
         row_item(OP_READ, 1, 0, 0)
      };

      reset = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            wait_idle();
            write_csr(directed[i].csr_idx, directed[i].csr_val);
         end else begin
            send_item(directed[i].item, directed[i].chk, directed[i].answer);
         end
      end
      dir_chk = 1'b0;

      // random problems, one store overflow case somewhere in the middle
      sent = 0;
      while (sent < NUM_ITEMS) begin
         if (!overflow_done && sent > NUM_ITEMS / 3) begin
            random_problem(1'b1, 1'b1);
            overflow_done = 1'b1;
         end else begin
            random_problem($urandom_range(0, 2) == 0, 1'b0);
         end
      end

      req_valid = 1'b0;
      while (delta_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
